// ===== hdl/bmsrdp_pkg.sv =====
// Shared types and constants for the BMS response deframer and parser.
`timescale 1ns / 1ps
package bmsrdp_pkg;

	localparam int PARSE_LEN = 12;

	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_COLON  = 8'h3A;
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [7:0] CHAR_BSLASH = 8'h5C;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;

	localparam logic [7:0] CMD_CURRENT = 8'h6C;
	localparam logic [7:0] CMD_FUEL    = 8'h67;
	localparam logic [7:0] CMD_INSUL   = 8'h49;
	localparam logic [7:0] CMD_VOLT    = 8'h76;

	localparam logic [15:0] FUEL_FULL        = 16'd1000;
	localparam logic [15:0] LOW_MV_RESET     = 16'd9999;
	localparam logic [7:0]  CELL_COUNT_RESET = 8'd16;
	localparam logic [7:0]  FIRST_CELL       = 8'd1;

	typedef enum logic [2:0] {
		KIND_STATUS  = 3'd0,
		KIND_BAD     = 3'd1,
		KIND_IGNORED = 3'd2,
		KIND_CURRENT = 3'd3,
		KIND_FUEL    = 3'd4,
		KIND_INSUL   = 3'd5,
		KIND_PACK_V  = 3'd6,
		KIND_CELL_V  = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		REQ_STATUS = 2'd0,
		REQ_BAD    = 2'd1,
		REQ_PARSE  = 2'd2
	} req_cls_t;

	typedef struct packed {
		req_cls_t                   cls;
		logic [7:0]                 status;
		logic [PARSE_LEN-1:0][7:0]  bytes;
	} entry_t;

	function automatic logic [15:0] digit16(input logic [7:0] b);
		return {8'h00, b} - {8'h00, CHAR_ZERO};
	endfunction

endpackage

// ===== hdl/bmsrdp_front.sv =====
// Front end: accepts bytes, builds the packet window and checksum, classifies requests.
`timescale 1ns / 1ps
module bmsrdp_front #(
	parameter int BUFFER_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	input  logic                 q_full,
	output logic                 push,
	output bmsrdp_pkg::entry_t   push_entry
);

	localparam int IDX_W = $clog2(BUFFER_DEPTH + 1);

	logic [IDX_W-1:0]                        wr_idx_q;
	logic [7:0]                              xor_q;
	logic [bmsrdp_pkg::PARSE_LEN-1:0][7:0]   buf_q;

	logic [IDX_W-1:0]                        idx_nxt;
	logic [bmsrdp_pkg::PARSE_LEN-1:0][7:0]   buf_nxt;
	logic                                    room;
	logic                                    is_status;
	logic                                    is_cr;
	logic                                    accept;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign is_status = rx_byte[7];
	assign is_cr     = (rx_byte == bmsrdp_pkg::CHAR_CR);
	assign room      = (wr_idx_q < IDX_W'(BUFFER_DEPTH));
	assign idx_nxt   = room ? (wr_idx_q + IDX_W'(1)) : wr_idx_q;

	always_comb begin
		buf_nxt = buf_q;
		for (int i = 0; i < bmsrdp_pkg::PARSE_LEN; i++) begin
			if (room && (wr_idx_q == IDX_W'(i))) begin
				buf_nxt[i] = rx_byte;
			end
		end
	end

	always_comb begin
		push_entry.status = rx_byte;
		push_entry.bytes  = buf_nxt;
		if (is_status) begin
			push_entry.cls = bmsrdp_pkg::REQ_STATUS;
		end else if ((xor_q != 8'h00) || (idx_nxt >= IDX_W'(BUFFER_DEPTH))) begin
			push_entry.cls = bmsrdp_pkg::REQ_BAD;
		end else begin
			push_entry.cls = bmsrdp_pkg::REQ_PARSE;
		end
	end

	assign push = accept && (is_status || is_cr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			xor_q    <= '0;
			buf_q    <= '0;
		end else if (accept && !is_status) begin
			buf_q <= buf_nxt;
			if (is_cr) begin
				wr_idx_q <= '0;
				xor_q    <= '0;
			end else begin
				wr_idx_q <= idx_nxt;
				xor_q    <= xor_q ^ rx_byte;
			end
		end
	end

endmodule

// ===== hdl/bmsrdp_queue.sv =====
// Two-entry request queue between front and back end.
`timescale 1ns / 1ps
module bmsrdp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bmsrdp_pkg::entry_t   push_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output bmsrdp_pkg::entry_t   head
);

	bmsrdp_pkg::entry_t  mem_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== hdl/bmsrdp_back.sv =====
// Back end: digit decode stage, then command dispatch, cell min/max tracking and result register.
`timescale 1ns / 1ps
module bmsrdp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  bmsrdp_pkg::entry_t   head,
	output logic                 pop,
	input  logic [7:0]           cell_count,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           kind,
	output logic signed [15:0]   value,
	output logic [7:0]           status_byte,
	output logic [7:0]           cell_id,
	output logic [15:0]          min_mv,
	output logic [15:0]          max_mv,
	output logic [7:0]           min_cell,
	output logic [7:0]           max_cell,
	output logic                 sweep_done
);

	// stage 1: decoded fields
	logic                   valid_s1;
	bmsrdp_pkg::req_cls_t   cls_s1;
	logic [7:0]             status_s1;
	logic                   hdr_ok_s1;
	logic [7:0]             cmd_s1;
	logic [7:0]             id_s1;
	logic [15:0]            v_s1;

	// result and tracking registers
	logic                   out_valid_q;
	bmsrdp_pkg::kind_t      kind_q;
	logic [15:0]            value_q;
	logic [7:0]             status_q;
	logic [7:0]             id_q;
	logic                   done_q;
	logic [15:0]            low_mv_q;
	logic [15:0]            high_mv_q;
	logic [7:0]             low_id_q;
	logic [7:0]             high_id_q;
	logic [7:0]             exp_cell_q;

	logic                   out_load;

	// stage 1 combinational decode
	logic [7:0]             id_c;
	logic [15:0]            mag_c;
	logic [15:0]            v_c;
	logic                   neg_c;
	logic                   hdr_c;
	logic [3:0][7:0]        vd_c;
	logic [7:0]             d1_c;
	logic [7:0]             d2_c;
	logic [7:0]             d3_c;

	assign out_load = valid_s1 && (!out_valid_q || out_ready);
	assign pop      = head_valid && (!valid_s1 || out_load);

	always_comb begin
		hdr_c = (head.bytes[0] == bmsrdp_pkg::CHAR_BSLASH) &&
			(head.bytes[4] == bmsrdp_pkg::CHAR_COLON);
		neg_c = (head.bytes[7] == bmsrdp_pkg::CHAR_MINUS);
		d1_c  = head.bytes[1] - bmsrdp_pkg::CHAR_ZERO;
		d2_c  = head.bytes[2] - bmsrdp_pkg::CHAR_ZERO;
		d3_c  = head.bytes[3] - bmsrdp_pkg::CHAR_ZERO;
		id_c  = 8'(d1_c * 8'd100) + 8'(d2_c * 8'd10) + d3_c;
		for (int k = 0; k < 4; k++) begin
			vd_c[k] = neg_c ? head.bytes[8 + k] : head.bytes[7 + k];
		end
		mag_c = 16'(bmsrdp_pkg::digit16(vd_c[0]) * 16'd1000) +
			16'(bmsrdp_pkg::digit16(vd_c[1]) * 16'd100) +
			16'(bmsrdp_pkg::digit16(vd_c[2]) * 16'd10) +
			bmsrdp_pkg::digit16(vd_c[3]);
		v_c   = neg_c ? ((~mag_c) + 16'd1) : mag_c;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cls_s1    <= head.cls;
			status_s1 <= head.status;
			hdr_ok_s1 <= hdr_c;
			cmd_s1    <= head.bytes[5];
			id_s1     <= id_c;
			v_s1      <= v_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= 1'b1;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 2 combinational dispatch
	bmsrdp_pkg::kind_t  kind_n;
	logic [15:0]        value_n;
	logic [7:0]         status_n;
	logic [7:0]         id_n;
	logic               done_n;
	logic               cell_hit;
	logic               id_zero;
	logic [7:0]         exp_inc;

	assign id_zero = (id_s1 == 8'd0);
	assign exp_inc = exp_cell_q + 8'd1;

	always_comb begin
		kind_n   = bmsrdp_pkg::KIND_IGNORED;
		value_n  = '0;
		status_n = '0;
		id_n     = '0;
		done_n   = 1'b0;
		cell_hit = 1'b0;
		unique case (cls_s1)
			bmsrdp_pkg::REQ_STATUS: begin
				kind_n   = bmsrdp_pkg::KIND_STATUS;
				status_n = status_s1;
			end
			bmsrdp_pkg::REQ_BAD: begin
				kind_n = bmsrdp_pkg::KIND_BAD;
			end
			bmsrdp_pkg::REQ_PARSE: begin
				if (hdr_ok_s1) begin
					if ((cmd_s1 == bmsrdp_pkg::CMD_CURRENT) && id_zero) begin
						kind_n  = bmsrdp_pkg::KIND_CURRENT;
						value_n = {v_s1[14:0], 1'b0};
						id_n    = id_s1;
					end else if ((cmd_s1 == bmsrdp_pkg::CMD_FUEL) && id_zero) begin
						kind_n  = bmsrdp_pkg::KIND_FUEL;
						value_n = bmsrdp_pkg::FUEL_FULL - v_s1;
						id_n    = id_s1;
					end else if ((cmd_s1 == bmsrdp_pkg::CMD_INSUL) && id_zero) begin
						kind_n  = bmsrdp_pkg::KIND_INSUL;
						value_n = v_s1;
						id_n    = id_s1;
					end else if ((cmd_s1 == bmsrdp_pkg::CMD_VOLT) && id_zero) begin
						kind_n  = bmsrdp_pkg::KIND_PACK_V;
						value_n = v_s1;
						id_n    = id_s1;
					end else if ((cmd_s1 == bmsrdp_pkg::CMD_VOLT) &&
						(id_s1 == exp_cell_q)) begin
						kind_n   = bmsrdp_pkg::KIND_CELL_V;
						value_n  = v_s1;
						id_n     = id_s1;
						done_n   = (id_s1 >= cell_count);
						cell_hit = 1'b1;
					end
				end
			end
			default: begin
				kind_n = bmsrdp_pkg::KIND_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q   <= kind_n;
			value_q  <= value_n;
			status_q <= status_n;
			id_q     <= id_n;
			done_q   <= done_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			low_mv_q    <= bmsrdp_pkg::LOW_MV_RESET;
			high_mv_q   <= '0;
			low_id_q    <= '0;
			high_id_q   <= '0;
			exp_cell_q  <= bmsrdp_pkg::FIRST_CELL;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (out_load && cell_hit) begin
				if (v_s1 < low_mv_q) begin
					low_mv_q <= v_s1;
					low_id_q <= id_s1;
				end
				if (v_s1 > high_mv_q) begin
					high_mv_q <= v_s1;
					high_id_q <= id_s1;
				end
				exp_cell_q <= (exp_inc > cell_count) ? bmsrdp_pkg::FIRST_CELL : exp_inc;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign value       = value_q;
	assign status_byte = status_q;
	assign cell_id     = id_q;
	assign sweep_done  = done_q;
	assign min_mv      = low_mv_q;
	assign max_mv      = high_mv_q;
	assign min_cell    = low_id_q;
	assign max_cell    = high_id_q;

endmodule

// ===== hdl/bms_response_deframer_parser_top.sv =====
// Top level of the BMS response deframer and parser.
// Results pass the two-entry queue, stage-1 and result registers, which decouple stalls.
// Throughput: one byte per cycle while the request queue is not full.
// Bytes that only extend a packet give no result; status bytes and CR give one each.
// Reset (arst_n low, asynchronous): packet window, index and checksum clear, min 9999,
// max and IDs zero, expected cell 1, cell_count 16; no clearing pass is needed.
`timescale 1ns / 1ps
module bms_response_deframer_parser_top #(
	parameter int BUFFER_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          kind,
	output logic signed [15:0]  value,
	output logic [7:0]          status_byte,
	output logic [7:0]          cell_id,
	output logic [15:0]         min_mv,
	output logic [15:0]         max_mv,
	output logic [7:0]          min_cell,
	output logic [7:0]          max_cell,
	output logic                sweep_done
);

	logic [7:0]           cell_cnt_q;
	logic                 q_full;
	logic                 push;
	bmsrdp_pkg::entry_t   push_entry;
	logic                 pop;
	logic                 head_valid;
	bmsrdp_pkg::entry_t   head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_cnt_q <= bmsrdp_pkg::CELL_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cell_cnt_q <= cfg_data;
		end
	end

	bmsrdp_front #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	bmsrdp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	bmsrdp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.cell_count  (cell_cnt_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.value       (value),
		.status_byte (status_byte),
		.cell_id     (cell_id),
		.min_mv      (min_mv),
		.max_mv      (max_mv),
		.min_cell    (min_cell),
		.max_cell    (max_cell),
		.sweep_done  (sweep_done)
	);

endmodule

// ===== hdl/bmsrdp_checker.sv =====
// Port-level assertions for the deframer and parser, bound to the top level.
`timescale 1ns / 1ps
module bmsrdp_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [7:0]          cfg_data,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [7:0]          rx_byte,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [2:0]          kind,
	input  logic signed [15:0]  value,
	input  logic [7:0]          status_byte,
	input  logic [7:0]          cell_id,
	input  logic [15:0]         min_mv,
	input  logic [15:0]         max_mv,
	input  logic [7:0]          min_cell,
	input  logic [7:0]          max_cell,
	input  logic                sweep_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value) &&
		$stable(min_mv) && $stable(max_mv))
		else $error("result changed while stalled");

	a_no_done_off_cell: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != bmsrdp_pkg::KIND_CELL_V) |-> !sweep_done)
		else $error("sweep_done on a non-cell result");

	a_plain_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((kind == bmsrdp_pkg::KIND_STATUS) || (kind == bmsrdp_pkg::KIND_BAD) ||
		(kind == bmsrdp_pkg::KIND_IGNORED)) |-> (value == 16'sd0) && (cell_id == 8'd0))
		else $error("status, bad or ignored result carries a value");

	a_min_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (min_mv <= bmsrdp_pkg::LOW_MV_RESET))
		else $error("minimum above its reset value");

	a_track_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid && out_ready) && (kind != bmsrdp_pkg::KIND_CELL_V) &&
		!$past(kind == bmsrdp_pkg::KIND_CELL_V) |-> $stable(max_mv) || !$past(out_valid))
		else $error("maximum moved without a cell result");

endmodule

bind bms_response_deframer_parser_top bmsrdp_checker u_bmsrdp_checker (.*);

// ===== tb/tb.sv =====
// Testbench for the BMS response deframer and parser: random serial traffic checked against a predictor.
`timescale 1ns / 1ps
module tb;

	localparam int DEPTH = 32;
	localparam int BYTES_PER_PHASE = 175;
	localparam int LONG_HOLD = 400;

	typedef struct {
		bmsrdp_pkg::kind_t kind;
		logic [15:0] value;
		logic [7:0]  status_byte;
		logic [7:0]  cell_id;
		logic [15:0] min_mv;
		logic [15:0] max_mv;
		logic [7:0]  min_cell;
		logic [7:0]  max_cell;
		logic        sweep_done;
	} reply_t;

	class reply_ledger;
		logic [7:0]  frame [DEPTH];
		int          fill;
		logic [7:0]  csum;
		logic [15:0] low_mv;
		logic [15:0] high_mv;
		logic [7:0]  low_id;
		logic [7:0]  high_id;
		logic [7:0]  next_cell;
		logic [7:0]  cell_count;
		reply_t      due_replies[$];
		int          errors;
		int          replies;
		int          sweeps;
		int          kind_hits [8];

		function new();
			foreach (frame[i])
				frame[i] = 8'h00;
			fill = 0;
			csum = 8'h00;
			low_mv = bmsrdp_pkg::LOW_MV_RESET;
			high_mv = 16'h0000;
			low_id = 8'h00;
			high_id = 8'h00;
			next_cell = bmsrdp_pkg::FIRST_CELL;
			cell_count = bmsrdp_pkg::CELL_COUNT_RESET;
			errors = 0;
			replies = 0;
			sweeps = 0;
			foreach (kind_hits[i])
				kind_hits[i] = 0;
		endfunction

		function reply_t reading(bmsrdp_pkg::kind_t k, logic [15:0] v, logic [7:0] st,
				logic [7:0] id, logic done);
			reply_t r;
			r.kind = k;
			r.value = v;
			r.status_byte = st;
			r.cell_id = id;
			r.min_mv = low_mv;
			r.max_mv = high_mv;
			r.min_cell = low_id;
			r.max_cell = high_id;
			r.sweep_done = done;
			return r;
		endfunction

		function logic [15:0] digit_at(int pos);
			logic [15:0] d;
			d = frame[pos] - bmsrdp_pkg::CHAR_ZERO;
			return d;
		endfunction

		function reply_t decode();
			int unsigned acc;
			logic [7:0]  id;
			logic [7:0]  cmd;
			logic [7:0]  nxt;
			logic [15:0] v;
			logic        neg;
			logic        done;
			int          b;
			if (frame[0] != bmsrdp_pkg::CHAR_BSLASH || frame[4] != bmsrdp_pkg::CHAR_COLON)
				return reading(bmsrdp_pkg::KIND_IGNORED, 16'h0, 8'h0, 8'h0, 1'b0);
			acc = digit_at(1) * 100 + digit_at(2) * 10 + digit_at(3);
			id = acc[7:0];
			cmd = frame[5];
			neg = (frame[7] == bmsrdp_pkg::CHAR_MINUS);
			b = neg ? 8 : 7;
			acc = digit_at(b) * 1000 + digit_at(b + 1) * 100 + digit_at(b + 2) * 10
				+ digit_at(b + 3);
			v = acc[15:0];
			if (neg)
				v = 16'd0 - v;
			if (cmd == bmsrdp_pkg::CMD_CURRENT && id == 8'd0)
				return reading(bmsrdp_pkg::KIND_CURRENT, v + v, 8'h0, id, 1'b0);
			if (cmd == bmsrdp_pkg::CMD_FUEL && id == 8'd0)
				return reading(bmsrdp_pkg::KIND_FUEL, bmsrdp_pkg::FUEL_FULL - v, 8'h0, id,
					1'b0);
			if (cmd == bmsrdp_pkg::CMD_INSUL && id == 8'd0)
				return reading(bmsrdp_pkg::KIND_INSUL, v, 8'h0, id, 1'b0);
			if (cmd == bmsrdp_pkg::CMD_VOLT && id == 8'd0)
				return reading(bmsrdp_pkg::KIND_PACK_V, v, 8'h0, id, 1'b0);
			if (cmd == bmsrdp_pkg::CMD_VOLT && id == next_cell) begin
				if (v < low_mv) begin
					low_mv = v;
					low_id = id;
				end
				if (v > high_mv) begin
					high_mv = v;
					high_id = id;
				end
				done = (id >= cell_count);
				nxt = next_cell + 8'd1;
				next_cell = (nxt > cell_count) ? bmsrdp_pkg::FIRST_CELL : nxt;
				return reading(bmsrdp_pkg::KIND_CELL_V, v, 8'h0, id, done);
			end
			return reading(bmsrdp_pkg::KIND_IGNORED, 16'h0, 8'h0, 8'h0, 1'b0);
		endfunction

		function void take_byte(logic [7:0] ch);
			reply_t r;
			if (ch >= 8'h80) begin
				due_replies.push_back(reading(bmsrdp_pkg::KIND_STATUS, 16'h0, ch, 8'h0, 1'b0));
				return;
			end
			if (fill < DEPTH) begin
				frame[fill] = ch;
				fill++;
			end
			if (ch != bmsrdp_pkg::CHAR_CR) begin
				csum ^= ch;
				return;
			end
			if (csum != 8'h00 || fill >= DEPTH)
				r = reading(bmsrdp_pkg::KIND_BAD, 16'h0, 8'h0, 8'h0, 1'b0);
			else
				r = decode();
			fill = 0;
			csum = 8'h00;
			due_replies.push_back(r);
		endfunction

		function void match_reply(reply_t got);
			reply_t want;
			replies++;
			kind_hits[got.kind]++;
			if (got.kind == bmsrdp_pkg::KIND_CELL_V && got.sweep_done)
				sweeps++;
			if (due_replies.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected reply: kind %0d value %0d", got.kind,
						$signed(got.value));
				return;
			end
			want = due_replies.pop_front();
			if (got.kind !== want.kind || got.value !== want.value
					|| got.status_byte !== want.status_byte || got.cell_id !== want.cell_id
					|| got.min_mv !== want.min_mv || got.max_mv !== want.max_mv
					|| got.min_cell !== want.min_cell || got.max_cell !== want.max_cell
					|| got.sweep_done !== want.sweep_done) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch at %0t: kind/value/status/id/min/max/done", $realtime);
					$display("  expected %0d %0d %02h %0d %0d@%0d %0d@%0d %0d", want.kind,
						$signed(want.value), want.status_byte, want.cell_id, want.min_mv,
						want.min_cell, want.max_mv, want.max_cell, want.sweep_done);
					$display("  actual   %0d %0d %02h %0d %0d@%0d %0d@%0d %0d", got.kind,
						$signed(got.value), got.status_byte, got.cell_id, got.min_mv,
						got.min_cell, got.max_mv, got.max_cell, got.sweep_done);
				end
			end
		endfunction

		function int pending();
			return due_replies.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  kind;
	logic signed [15:0] value;
	logic [7:0]  status_byte;
	logic [7:0]  cell_id;
	logic [15:0] min_mv;
	logic [15:0] max_mv;
	logic [7:0]  min_cell;
	logic [7:0]  max_cell;
	logic        sweep_done;

	reply_ledger ledger = new();
	bit          calm = 1'b0;
	bit          stall_req = 1'b0;
	int          bytes_sent = 0;

	bms_response_deframer_parser_top #(
		.BUFFER_DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.value(value),
		.status_byte(status_byte),
		.cell_id(cell_id),
		.min_mv(min_mv),
		.max_mv(max_mv),
		.min_cell(min_cell),
		.max_cell(max_cell),
		.sweep_done(sweep_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		reply_t got;
		if (arst_n && out_valid && out_ready) begin
			got.kind = bmsrdp_pkg::kind_t'(kind);
			got.value = value;
			got.status_byte = status_byte;
			got.cell_id = cell_id;
			got.min_mv = min_mv;
			got.max_mv = max_mv;
			got.min_cell = min_cell;
			got.max_cell = max_cell;
			got.sweep_done = sweep_done;
			ledger.match_reply(got);
		end
	end

	// result side: random back-pressure, one long hold-off on request
	initial begin
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (stall_req) begin
				out_ready <= 1'b0;
				stall_req = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		if (!calm && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		ledger.take_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic write_cell_count(input logic [7:0] n);
		in_valid <= 1'b0;
		while (ledger.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do @(posedge clk); while (!cfg_ready);
		ledger.cell_count = n;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_reply(input int id, input logic [7:0] cmd, input bit neg, input int mag,
			input bit wild, input bit corrupt);
		logic [7:0] body[$];
		logic [7:0] x;
		int         t;
		int         scale;
		body.push_back(bmsrdp_pkg::CHAR_BSLASH);
		t = id / 100;
		body.push_back(bmsrdp_pkg::CHAR_ZERO + t[7:0]);
		t = (id / 10) % 10;
		body.push_back(bmsrdp_pkg::CHAR_ZERO + t[7:0]);
		t = id % 10;
		body.push_back(bmsrdp_pkg::CHAR_ZERO + t[7:0]);
		body.push_back(bmsrdp_pkg::CHAR_COLON);
		body.push_back(cmd);
		t = $urandom_range(8'h20, 8'h7E);
		body.push_back(t[7:0]);
		if (neg)
			body.push_back(bmsrdp_pkg::CHAR_MINUS);
		scale = 1000;
		for (int i = 0; i < 4; i++) begin
			if (wild && $urandom_range(0, 3) == 0) begin
				t = $urandom_range(0, 127);
				if (t == bmsrdp_pkg::CHAR_CR)
					t = t + 1;
			end else begin
				t = bmsrdp_pkg::CHAR_ZERO + (mag / scale) % 10;
			end
			body.push_back(t[7:0]);
			scale = scale / 10;
		end
		x = 8'h00;
		foreach (body[i])
			x ^= body[i];
		if (x == bmsrdp_pkg::CHAR_CR) begin
			body.push_back(8'h01);
			x ^= 8'h01;
		end
		if (x != 8'h00)
			body.push_back(x);
		if (corrupt) begin
			t = $urandom_range(1, 127);
			if (t == bmsrdp_pkg::CHAR_CR)
				t = t + 1;
			body.push_back(t[7:0]);
		end
		body.push_back(bmsrdp_pkg::CHAR_CR);
		foreach (body[i]) begin
			if ($urandom_range(0, 24) == 0) begin
				t = $urandom_range(8'h80, 8'hFF);
				push_byte(t[7:0]);
			end
			push_byte(body[i]);
		end
	endtask

	task automatic send_raw(input int n, input bit balance);
		logic [7:0] body[$];
		logic [7:0] x;
		int         t;
		do begin
			body = {};
			x = 8'h00;
			for (int i = 0; i < n; i++) begin
				t = $urandom_range(0, 127);
				if (t == bmsrdp_pkg::CHAR_CR)
					t = 10;
				body.push_back(t[7:0]);
				x ^= t[7:0];
			end
			if (balance && n > 0) begin
				x ^= body[n - 1];
				body[n - 1] = x;
			end
		end while (balance && n > 0 && x == bmsrdp_pkg::CHAR_CR);
		body.push_back(bmsrdp_pkg::CHAR_CR);
		foreach (body[i])
			push_byte(body[i]);
	endtask

	task automatic random_reply();
		int         pick;
		int         id;
		int         t;
		logic [7:0] cmd;
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			id = 0;
			case ($urandom_range(0, 3))
				0: cmd = bmsrdp_pkg::CMD_CURRENT;
				1: cmd = bmsrdp_pkg::CMD_FUEL;
				2: cmd = bmsrdp_pkg::CMD_INSUL;
				default: cmd = bmsrdp_pkg::CMD_VOLT;
			endcase
		end else begin
			id = ledger.next_cell;
			cmd = bmsrdp_pkg::CMD_VOLT;
			if (pick == 8)
				id = $urandom_range(0, 999);
			if (pick == 9 && id + 256 <= 999)
				id = id + 256;
		end
		if ($urandom_range(0, 15) == 0) begin
			t = $urandom_range(8'h41, 8'h7A);
			cmd = t[7:0];
		end
		send_reply(id, cmd, $urandom_range(0, 1), $urandom_range(0, 9999),
			$urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0);
	endtask

	task automatic random_traffic(input int stop_at);
		int sel;
		int n;
		int t;
		while (bytes_sent < stop_at) begin
			sel = $urandom_range(0, 99);
			if (sel < 72) begin
				random_reply();
			end else if (sel < 80) begin
				send_raw($urandom_range(0, 11), $urandom_range(0, 1));
			end else if (sel < 86) begin
				case ($urandom_range(0, 3))
					0: n = DEPTH - 2;
					1: n = DEPTH - 1;
					2: n = DEPTH;
					default: n = $urandom_range(DEPTH + 1, DEPTH + 13);
				endcase
				send_raw(n, $urandom_range(0, 3) != 0);
			end else if (sel < 93) begin
				repeat ($urandom_range(1, 4)) begin
					t = $urandom_range(8'h80, 8'hFF);
					push_byte(t[7:0]);
				end
			end else begin
				repeat ($urandom_range(1, 5)) begin
					t = $urandom_range(0, 255);
					push_byte(t[7:0]);
				end
			end
		end
	endtask

	initial begin
		logic [7:0] counts [5];
		int         t;
		counts[0] = 8'd1;
		counts[1] = 8'd255;
		counts[2] = 8'd3;
		t = $urandom_range(2, 254);
		counts[3] = t[7:0];
		counts[4] = bmsrdp_pkg::CELL_COUNT_RESET;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// status extremes, an empty packet over a cleared buffer, a full-scale negative cell reading
		push_byte(8'h80);
		push_byte(8'hFF);
		push_byte(bmsrdp_pkg::CHAR_CR);
		send_reply(1, bmsrdp_pkg::CMD_VOLT, 1'b1, 9999, 1'b0, 1'b0);

		for (int p = 0; p < 6; p++) begin
			if (p > 0)
				write_cell_count(counts[p - 1]);
			if (p == 2)
				stall_req = 1'b1;
			if (p == 5)
				calm = 1'b1;
			random_traffic((p + 1) * BYTES_PER_PHASE);
		end

		in_valid <= 1'b0;
		while (ledger.pending() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		$display("covered %0d bytes over six cell_count settings: %0d replies,",
			bytes_sent, ledger.replies);
		$display("  %0d status, %0d bad, %0d ignored",
			ledger.kind_hits[bmsrdp_pkg::KIND_STATUS], ledger.kind_hits[bmsrdp_pkg::KIND_BAD],
			ledger.kind_hits[bmsrdp_pkg::KIND_IGNORED]);
		$display("readings: current %0d fuel %0d insulation %0d pack %0d cell %0d (%0d sweep ends)",
			ledger.kind_hits[bmsrdp_pkg::KIND_CURRENT], ledger.kind_hits[bmsrdp_pkg::KIND_FUEL],
			ledger.kind_hits[bmsrdp_pkg::KIND_INSUL], ledger.kind_hits[bmsrdp_pkg::KIND_PACK_V],
			ledger.kind_hits[bmsrdp_pkg::KIND_CELL_V], ledger.sweeps);
		if (ledger.errors == 0 && ledger.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
